// File: hw/rtl/nad_pkg.sv
// Shared types and fixed-point constants for the activation unit.
package nad_pkg;

    typedef enum logic [1:0] {
        OP_LOGISTIC = 2'd0,
        OP_BIPOLAR  = 2'd1,
        OP_CLAMP    = 2'd2,
        OP_RELU     = 2'd3
    } nad_op_t;

    // Q32 datapath widths
    localparam int Q_W   = 32;
    localparam int DIV_W = 34;

    // round(e^-1 * 2^32)
    localparam logic [Q_W-1:0] EXP_M1_Q32 = 32'd1580030169;

    // integer part of |t| at or above this gives e^-|t| = 0
    localparam int EXP_ZERO_LIMIT = 48;
    localparam int E_CNT_W        = 6;

    // Taylor terms beyond x^12/12! truncate to zero in Q32 since 13! > 2^32
    localparam int EXP_LAST_TERM = 12;

endpackage

// File: hw/rtl/nad_if.sv
// Stream interfaces for the activation unit: input beats and result beats.
interface nad_in_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pre_activation;
    logic signed [DATA_WIDTH-1:0] bias;
    logic [1:0]                   opcode;

    modport source (output valid, pre_activation, bias, opcode, input ready);
    modport sink   (input valid, pre_activation, bias, opcode, output ready);
endinterface

interface nad_out_if #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] activation;
    logic [FRAC_BITS:0]           derivative;
    logic                         sum_saturated;

    modport source (output valid, activation, derivative, sum_saturated, input ready);
    modport sink   (input valid, activation, derivative, sum_saturated, output ready);
endinterface

// File: hw/rtl/neural_activation_with_derivative.sv
// NMUL is the number of e^-1 multiply stages (min(47, 2^(DATA_WIDTH-1-FRAC_BITS)), at least 1).
// Throughput: one beat per cycle while no beat waits in the skid stage; the Taylor chain
// (3 stages a term) and the two 32-stage restoring dividers are fully pipelined behind a
// skid stage at the output.
// Reset clears only the valid bits and the skid flag; payload registers are not reset.
module neural_activation_with_derivative #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    nad_in_if.sink     sample,
    nad_out_if.source  result
);
    import nad_pkg::*;

    localparam int MAX_N = (DATA_WIDTH - 1 >= FRAC_BITS) ?
                           (1 << (DATA_WIDTH - 1 - FRAC_BITS)) : 0;
    localparam int NMUL  = (MAX_N >= EXP_ZERO_LIMIT) ? (EXP_ZERO_LIMIT - 1) :
                           ((MAX_N < 1) ? 1 : MAX_N);
    localparam int NT     = EXP_LAST_TERM - 1;
    localparam int RND_SH = Q_W - FRAC_BITS;

    localparam logic [Q_W+2:0]   RND_HALF = 35'(1) << (RND_SH - 1);
    localparam logic [DIV_W-1:0] Q32_ONE  = 34'(1) << Q_W;
    localparam logic [Q_W:0]     Q32_ONE1 = 33'(1) << Q_W;
    localparam logic [Q_W-1:0]   HALF_Q32 = 32'(1) << (Q_W - 1);

    localparam logic signed [33:0] MAX_W = (34'sd1 <<< (DATA_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] MIN_W = -MAX_W - 34'sd1;
    localparam logic signed [33:0] ONE_W = 34'sd1 <<< FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_D = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        nad_op_t               op;
        logic                  neg;
        logic                  sat;
        logic [E_CNT_W-1:0]    n_c;
        logic                  ez;
        logic [DATA_WIDTH-1:0] alt_act;
        logic [FRAC_BITS:0]    alt_der;
    } side_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] act;
        logic [FRAC_BITS:0]    der;
        logic                  sat;
    } res_t;

    localparam int SIDE_W = $bits(side_t);

    logic adv;

    // ---------------------------------------------------------------- saturating add
    logic                         s0_valid_reg;
    logic signed [DATA_WIDTH-1:0] s0_t_reg;
    logic signed [DATA_WIDTH-1:0] s0_t_next;
    logic                         s0_sat_reg;
    logic                         s0_sat_next;
    nad_op_t                      s0_op_reg;
    logic [DATA_WIDTH:0]          s0_wide;

    always_comb
    begin
        s0_wide     = {sample.pre_activation[DATA_WIDTH-1], sample.pre_activation}
                    + {sample.bias[DATA_WIDTH-1], sample.bias};
        s0_sat_next = s0_wide[DATA_WIDTH] ^ s0_wide[DATA_WIDTH-1];
        if (!s0_sat_next)
        begin
            s0_t_next = s0_wide[DATA_WIDTH-1:0];
        end
        else if (s0_wide[DATA_WIDTH])
        begin
            s0_t_next = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
        end
        else
        begin
            s0_t_next = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
        end
    end

    // ---------------------------------------------------------------- magnitude split
    logic                  s1_valid_reg;
    logic [Q_W-1:0]        s1_fq_reg;
    logic [Q_W-1:0]        s1_fq_next;
    logic [DIV_W-1:0]      s1_sum_reg;
    side_t                 s1_side_reg;
    side_t                 s1_side_next;
    logic [DATA_WIDTH-1:0] s1_mag;
    logic [DATA_WIDTH-1:0] s1_n_full;
    logic signed [33:0]    s1_t_w;

    always_comb
    begin
        s1_side_next.op  = s0_op_reg;
        s1_side_next.sat = s0_sat_reg;
        s1_side_next.neg = s0_t_reg[DATA_WIDTH-1];
        s1_mag = s1_side_next.neg ? (~s0_t_reg + 1'b1) : s0_t_reg;
        s1_n_full = s1_mag >> FRAC_BITS;
        s1_side_next.ez  = (s1_n_full >= DATA_WIDTH'(EXP_ZERO_LIMIT));
        s1_side_next.n_c = s1_side_next.ez ? '0 : s1_n_full[E_CNT_W-1:0];
        // fraction moved to Q32; integer bits fall off the top
        s1_fq_next = 32'(s1_mag) << RND_SH;
        s1_t_w = 34'(s0_t_reg);
        case (s0_op_reg)
            OP_CLAMP:
            begin
                if (s1_t_w < -ONE_W)
                begin
                    s1_side_next.alt_act = DATA_WIDTH'(-ONE_W);
                    s1_side_next.alt_der = '0;
                end
                else if (s1_t_w > ONE_W)
                begin
                    s1_side_next.alt_act = DATA_WIDTH'(ONE_W);
                    s1_side_next.alt_der = '0;
                end
                else
                begin
                    s1_side_next.alt_act = s0_t_reg;
                    s1_side_next.alt_der = ONE_D;
                end
            end
            OP_RELU:
            begin
                if (s1_side_next.neg)
                begin
                    s1_side_next.alt_act = '0;
                    s1_side_next.alt_der = '0;
                end
                else
                begin
                    s1_side_next.alt_act = s0_t_reg;
                    s1_side_next.alt_der = ONE_D;
                end
            end
            default:
            begin
                s1_side_next.alt_act = '0;
                s1_side_next.alt_der = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= sample.valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_t_reg    <= s0_t_next;
            s0_sat_reg  <= s0_sat_next;
            s0_op_reg   <= nad_op_t'(sample.opcode);
            s1_fq_reg   <= s1_fq_next;
            s1_sum_reg  <= Q32_ONE + 34'(s1_fq_next);
            s1_side_reg <= s1_side_next;
        end
    end

    // ---------------------------------------------------------------- e^f Taylor chain
    logic             ch_valid [NT+1];
    logic [Q_W-1:0]   ch_term  [NT+1];
    logic [Q_W-1:0]   ch_fq    [NT+1];
    logic [DIV_W-1:0] ch_sum   [NT+1];
    side_t            ch_side  [NT+1];

    // first term is the fraction itself
    assign ch_valid[0] = s1_valid_reg;
    assign ch_term[0]  = s1_fq_reg;
    assign ch_fq[0]    = s1_fq_reg;
    assign ch_sum[0]   = s1_sum_reg;
    assign ch_side[0]  = s1_side_reg;

    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int             K     = j + 2;
        localparam logic [Q_W-1:0] RECIP = 32'((64'd1 << Q_W) / K);
        localparam logic [Q_W-1:0] K_Q   = 32'(K);

        logic             a_valid_reg;
        logic [Q_W-1:0]   a_p_reg;
        logic [Q_W-1:0]   a_fq_reg;
        logic [DIV_W-1:0] a_sum_reg;
        side_t            a_side_reg;
        logic             b_valid_reg;
        logic [Q_W-1:0]   b_p_reg;
        logic [Q_W-1:0]   b_q_reg;
        logic [Q_W-1:0]   b_fq_reg;
        logic [DIV_W-1:0] b_sum_reg;
        side_t            b_side_reg;
        logic             c_valid_reg;
        logic [Q_W-1:0]   c_term_reg;
        logic [Q_W-1:0]   c_fq_reg;
        logic [DIV_W-1:0] c_sum_reg;
        side_t            c_side_reg;

        logic [2*Q_W-1:0] a_prod;
        logic [Q_W-1:0]   a_p_next;
        logic [2*Q_W-1:0] b_prod;
        logic [Q_W-1:0]   b_q_next;
        logic [Q_W-1:0]   c_rem;
        logic [Q_W-1:0]   c_term_next;

        always_comb
        begin
            a_prod   = 64'(ch_term[j]) * 64'(ch_fq[j]);
            a_p_next = a_prod[2*Q_W-1:Q_W];
            // reciprocal estimate is exact or one short
            b_prod   = 64'(a_p_reg) * 64'(RECIP);
            b_q_next = b_prod[2*Q_W-1:Q_W];
            c_rem    = b_p_reg - b_q_reg * K_Q;
            c_term_next = (c_rem >= K_Q) ? (b_q_reg + 32'd1) : b_q_reg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_valid_reg <= 1'b0;
                b_valid_reg <= 1'b0;
                c_valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                a_valid_reg <= ch_valid[j];
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_p_reg    <= a_p_next;
                a_fq_reg   <= ch_fq[j];
                a_sum_reg  <= ch_sum[j];
                a_side_reg <= ch_side[j];
                b_p_reg    <= a_p_reg;
                b_q_reg    <= b_q_next;
                b_fq_reg   <= a_fq_reg;
                b_sum_reg  <= a_sum_reg;
                b_side_reg <= a_side_reg;
                c_term_reg <= c_term_next;
                c_fq_reg   <= b_fq_reg;
                c_sum_reg  <= b_sum_reg + 34'(c_term_next);
                c_side_reg <= b_side_reg;
            end
        end

        assign ch_valid[j+1] = c_valid_reg;
        assign ch_term[j+1]  = c_term_reg;
        assign ch_fq[j+1]    = c_fq_reg;
        assign ch_sum[j+1]   = c_sum_reg;
        assign ch_side[j+1]  = c_side_reg;
    end

    // ---------------------------------------------------------------- e^-f
    logic              d1_valid;
    logic [Q_W-1:0]    d1_quot;
    logic [SIDE_W-1:0] d1_side_vec;
    side_t             d1_side;

    nad_recip_div #(
        .SIDE_W (SIDE_W)
    ) u_div_exp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (ch_valid[NT]),
        .in_divisor (ch_sum[NT]),
        .in_side    (SIDE_W'(ch_side[NT])),
        .out_valid  (d1_valid),
        .out_quot   (d1_quot),
        .out_side   (d1_side_vec)
    );

    assign d1_side = side_t'(d1_side_vec);

    // ---------------------------------------------------------------- times e^-1, n times
    logic           m_valid [NMUL+1];
    logic [Q_W-1:0] m_e     [NMUL+1];
    side_t          m_side  [NMUL+1];

    assign m_valid[0] = d1_valid;
    assign m_e[0]     = d1_side.ez ? '0 : d1_quot;
    assign m_side[0]  = d1_side;

    for (genvar i = 0; i < NMUL; i++) begin : g_emul
        logic             valid_reg;
        logic [Q_W-1:0]   e_reg;
        logic [Q_W-1:0]   e_next;
        side_t            side_reg;
        logic [2*Q_W-1:0] prod;

        always_comb
        begin
            prod = 64'(m_e[i]) * 64'(EXP_M1_Q32) + 64'(HALF_Q32);
            e_next = (E_CNT_W'(i) < m_side[i].n_c) ? prod[2*Q_W-1:Q_W] : m_e[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg <= m_valid[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                e_reg    <= e_next;
                side_reg <= m_side[i];
            end
        end

        assign m_valid[i+1] = valid_reg;
        assign m_e[i+1]     = e_reg;
        assign m_side[i+1]  = side_reg;
    end

    // ---------------------------------------------------------------- logistic of |t|
    logic              d2_valid;
    logic [Q_W-1:0]    d2_quot;
    logic [SIDE_W-1:0] d2_side_vec;
    side_t             d2_side;

    nad_recip_div #(
        .SIDE_W (SIDE_W)
    ) u_div_sig (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (m_valid[NMUL]),
        .in_divisor (Q32_ONE + 34'(m_e[NMUL])),
        .in_side    (SIDE_W'(m_side[NMUL])),
        .out_valid  (d2_valid),
        .out_quot   (d2_quot),
        .out_side   (d2_side_vec)
    );

    assign d2_side = side_t'(d2_side_vec);

    // ---------------------------------------------------------------- mirror, s(1-s), round
    logic             flip_valid_reg;
    logic [Q_W-1:0]   flip_s_reg;
    logic [Q_W-1:0]   flip_s_next;
    logic [Q_W-1:0]   flip_c_reg;
    logic [Q_W-1:0]   flip_c_next;
    side_t            flip_side_reg;
    logic             dp_valid_reg;
    logic [Q_W-1:0]   dp_s_reg;
    logic [Q_W-1:0]   dp_d_reg;
    logic [2*Q_W-1:0] dp_prod;
    side_t            dp_side_reg;
    logic             fin_valid_reg;
    res_t             fin_res_reg;
    res_t             fin_res_next;
    logic             fin_bip;
    logic [Q_W+2:0]   fin_act_sum;
    logic [Q_W+2:0]   fin_der_sum;
    logic signed [33:0] fin_act_w;

    always_comb
    begin
        // s(-|t|) = 1 - s(|t|); neither side can reach zero
        flip_s_next = d2_side.neg ? 32'(Q32_ONE1 - 33'(d2_quot)) : d2_quot;
        flip_c_next = 32'(Q32_ONE1 - 33'(flip_s_next));
        dp_prod     = 64'(flip_s_reg) * 64'(flip_c_reg);

        fin_bip     = (dp_side_reg.op == OP_BIPOLAR);
        fin_act_sum = (fin_bip ? {2'b00, dp_s_reg, 1'b0} : {3'b000, dp_s_reg}) + RND_HALF;
        fin_der_sum = (fin_bip ? {2'b00, dp_d_reg, 1'b0} : {3'b000, dp_d_reg}) + RND_HALF;
        fin_act_w   = $signed(34'(fin_act_sum >> RND_SH)) - (fin_bip ? ONE_W : 34'sd0);

        fin_res_next.sat = dp_side_reg.sat;
        case (dp_side_reg.op)
            OP_LOGISTIC, OP_BIPOLAR:
            begin
                if (fin_act_w > MAX_W)
                begin
                    fin_res_next.act = DATA_WIDTH'(MAX_W);
                end
                else if (fin_act_w < MIN_W)
                begin
                    fin_res_next.act = DATA_WIDTH'(MIN_W);
                end
                else
                begin
                    fin_res_next.act = DATA_WIDTH'(fin_act_w);
                end
                fin_res_next.der = (FRAC_BITS + 1)'(fin_der_sum >> RND_SH);
            end
            default:
            begin
                fin_res_next.act = dp_side_reg.alt_act;
                fin_res_next.der = dp_side_reg.alt_der;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_valid_reg <= 1'b0;
            dp_valid_reg   <= 1'b0;
            fin_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            flip_valid_reg <= d2_valid;
            dp_valid_reg   <= flip_valid_reg;
            fin_valid_reg  <= dp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flip_s_reg    <= flip_s_next;
            flip_c_reg    <= flip_c_next;
            flip_side_reg <= d2_side;
            dp_s_reg      <= flip_s_reg;
            dp_d_reg      <= dp_prod[2*Q_W-1:Q_W];
            dp_side_reg   <= flip_side_reg;
            fin_res_reg   <= fin_res_next;
        end
    end

    // ---------------------------------------------------------------- output and skid
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;
    res_t out_res_next;
    logic skid_full_reg;
    logic skid_full_next;
    res_t skid_res_reg;
    res_t skid_res_next;

    // the whole pipeline holds only while the skid beat waits
    assign adv          = !skid_full_reg;
    assign sample.ready = adv;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        skid_full_next = skid_full_reg;
        skid_res_next  = skid_res_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (skid_full_reg)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_res_next   = skid_res_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (fin_valid_reg)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_res_next   = fin_res_reg;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_res_next  = fin_res_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.activation    = out_res_reg.act;
    assign result.derivative    = out_res_reg.der;
    assign result.sum_saturated = out_res_reg.sat;

endmodule

// File: hw/rtl/nad_recip_div.sv
// Pipelined restoring divider: floor((2^64-1) / divisor), one quotient bit per stage.
module nad_recip_div #(
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [nad_pkg::DIV_W-1:0]  in_divisor,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [nad_pkg::Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0]          out_side
);
    import nad_pkg::*;

    // top Q_W bits of the all-ones dividend, always below the divisor
    localparam logic [DIV_W-1:0] REM_INIT = {{(DIV_W - Q_W){1'b0}}, {Q_W{1'b1}}};

    logic              st_valid [Q_W+1];
    logic [DIV_W-1:0]  st_rem   [Q_W+1];
    logic [DIV_W-1:0]  st_dsr   [Q_W+1];
    logic [Q_W-1:0]    st_quot  [Q_W+1];
    logic [SIDE_W-1:0] st_side  [Q_W+1];

    assign st_valid[0] = in_valid;
    assign st_rem[0]   = REM_INIT;
    assign st_dsr[0]   = in_divisor;
    assign st_quot[0]  = '0;
    assign st_side[0]  = in_side;

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic              valid_reg;
        logic [DIV_W-1:0]  rem_reg;
        logic [DIV_W-1:0]  rem_next;
        logic [DIV_W-1:0]  dsr_reg;
        logic [Q_W-1:0]    quot_reg;
        logic [Q_W-1:0]    quot_next;
        logic [SIDE_W-1:0] side_reg;
        logic [DIV_W:0]    shifted;
        logic [DIV_W+1:0]  diff;

        always_comb
        begin
            // shift in the next dividend bit, always a one
            shifted   = {st_rem[g], 1'b1};
            diff      = {1'b0, shifted} - {2'b00, st_dsr[g]};
            if (diff[DIV_W+1])
            begin
                rem_next  = shifted[DIV_W-1:0];
                quot_next = {st_quot[g][Q_W-2:0], 1'b0};
            end
            else
            begin
                rem_next  = diff[DIV_W-1:0];
                quot_next = {st_quot[g][Q_W-2:0], 1'b1};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= st_valid[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                dsr_reg  <= st_dsr[g];
                quot_reg <= quot_next;
                side_reg <= st_side[g];
            end
        end

        assign st_valid[g+1] = valid_reg;
        assign st_rem[g+1]   = rem_reg;
        assign st_dsr[g+1]   = dsr_reg;
        assign st_quot[g+1]  = quot_reg;
        assign st_side[g+1]  = side_reg;
    end

    assign out_valid = st_valid[Q_W];
    assign out_quot  = st_quot[Q_W];
    assign out_side  = st_side[Q_W];

endmodule

// File: hw/rtl/nad_checker.sv
// Port-level checks for the activation unit and their binding to the top level.
module nad_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] activation,
    input logic [FRAC_BITS:0]    derivative,
    input logic                  sum_saturated
);
    import nad_pkg::*;

    localparam int MAX_N = (DATA_WIDTH - 1 >= FRAC_BITS) ?
                           (1 << (DATA_WIDTH - 1 - FRAC_BITS)) : 0;
    localparam int NMUL  = (MAX_N >= EXP_ZERO_LIMIT) ? (EXP_ZERO_LIMIT - 1) :
                           ((MAX_N < 1) ? 1 : MAX_N);
    // pipeline registers plus output and skid stages
    localparam int CAP   = 104 + NMUL;
    localparam int CNT_W = 9;

    localparam logic [FRAC_BITS:0] DER_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready)
        begin
            count_next = count_next + 1'b1;
        end
        if (out_valid && out_ready)
        begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(activation)
            && $stable(derivative) && $stable(sum_saturated))
        else $error("result beat changed while stalled");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input held off without a stalled result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result beat with no beat in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAP))
        else $error("more beats in flight than pipeline stages");

    a_der_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> derivative <= DER_ONE)
        else $error("derivative above one");

endmodule

bind neural_activation_with_derivative nad_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_nad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .activation    (result.activation),
    .derivative    (result.derivative),
    .sum_saturated (result.sum_saturated)
);

// File: bench/tb_top.sv
// Self-checking bench for the activation unit: random and corner beats against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nad_pkg::*;

    localparam int DW           = 16;
    localparam int FB           = 12;
    localparam int RANDOM_BEATS = 1330;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic signed [DW-1:0] act;
        logic [FB:0]          der;
        logic                 sat;
    } act_result_t;

    class act_scoreboard;
        act_result_t expected_acts[$];
        int          errors   = 0;
        int          beats_in = 0;

        static function longint unsigned round_q32(longint unsigned v);
            return (v + (64'd1 << (31 - FB))) >> (32 - FB);
        endfunction

        // s(|t|) in unsigned Q32, t carrying FB fraction bits
        static function longint unsigned logistic_q32(longint unsigned mag);
            longint unsigned n, f, fq, term, sum, e, i;
            int unsigned     k;
            n = mag >> FB;
            f = mag & ((64'd1 << FB) - 1);
            if (n >= EXP_ZERO_LIMIT) begin
                e = 0;
            end else begin
                fq   = f << (32 - FB);
                term = 64'd1 << 32;
                sum  = 64'd1 << 32;
                for (k = 1; k <= 20; k++) begin
                    term = ((term * fq) >> 32) / k;
                    sum  = sum + term;
                end
                e = 64'hFFFF_FFFF_FFFF_FFFF / sum;
                for (i = 0; i < n; i++)
                    e = (e * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
            end
            return 64'hFFFF_FFFF_FFFF_FFFF / ((64'd1 << 32) + e);
        endfunction

        static function act_result_t activate(logic signed [DW-1:0] x,
                                              logic signed [DW-1:0] b, nad_op_t op);
            longint          t, maxv, minv, one, act;
            longint unsigned mag, s, d, der;
            act_result_t     r;
            maxv  = (longint'(1) <<< (DW - 1)) - 1;
            minv  = -maxv - 1;
            one   = longint'(1) <<< FB;
            t     = longint'(x) + longint'(b);
            r.sat = 1'b0;
            if (t > maxv) begin
                t     = maxv;
                r.sat = 1'b1;
            end
            if (t < minv) begin
                t     = minv;
                r.sat = 1'b1;
            end
            case (op)
                OP_LOGISTIC, OP_BIPOLAR:
                begin
                    mag = (t < 0) ? longint'(-t) : longint'(t);
                    s   = logistic_q32(mag);
                    if (t < 0)
                        s = (64'd1 << 32) - s;
                    d = (s * ((64'd1 << 32) - s)) >> 32;
                    if (op == OP_LOGISTIC) begin
                        act = longint'(round_q32(s));
                        der = round_q32(d);
                    end else begin
                        act = longint'(round_q32(2 * s)) - one;
                        der = round_q32(2 * d);
                    end
                    if (act > maxv)
                        act = maxv;
                    if (act < minv)
                        act = minv;
                end
                OP_CLAMP:
                begin
                    if (t < -one) begin
                        act = -one;
                        der = 0;
                    end else if (t > one) begin
                        act = one;
                        der = 0;
                    end else begin
                        act = t;
                        der = one;
                    end
                end
                default:
                begin
                    act = (t < 0) ? 0 : t;
                    der = (t < 0) ? 0 : one;
                end
            endcase
            r.act = act[DW-1:0];
            r.der = der[FB:0];
            return r;
        endfunction

        function void note_input(logic signed [DW-1:0] x, logic signed [DW-1:0] b,
                                 nad_op_t op);
            expected_acts.push_back(activate(x, b, op));
            beats_in++;
        endfunction

        function void check_result(act_result_t got);
            act_result_t want;
            if (expected_acts.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result beat: act %0d der %0d sat %0d",
                             got.act, got.der, got.sat);
                errors++;
                return;
            end
            want = expected_acts.pop_front();
            if (got.act !== want.act || got.der !== want.der || got.sat !== want.sat) begin
                if (errors < 10)
                    $display("result error: act %0d/%0d der %0d/%0d sat %0d/%0d (want/got)",
                             want.act, got.act, want.der, got.der, want.sat, got.sat);
                errors++;
            end
        endfunction

        function int waiting();
            return expected_acts.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on = 1'b1;
    int   cycles  = 0;

    act_scoreboard sb = new;

    nad_in_if  #(.DATA_WIDTH(DW))                  sample_if ();
    nad_out_if #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) result_if ();

    neural_activation_with_derivative #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_if),
        .result(result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_if.valid && sample_if.ready)
            sb.note_input(sample_if.pre_activation, sample_if.bias,
                          nad_op_t'(sample_if.opcode));
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_result({result_if.activation, result_if.derivative,
                             result_if.sum_saturated});
    end

    // Receiver: short random stalls, plus one long hold to back the pipeline up
    initial
    begin
        bit held;
        held = 1'b0;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!held && sb.beats_in >= 300) begin
                held = 1'b1;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_if.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_if.ready <= 1'b1;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic signed [DW-1:0] x, input logic signed [DW-1:0] b,
                             input nad_op_t op);
        sample_if.valid          <= 1'b1;
        sample_if.pre_activation <= x;
        sample_if.bias           <= b;
        sample_if.opcode         <= op;
        do
            @(posedge clk);
        while (!sample_if.ready);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic random_beat();
        int xi, bi;
        case ($urandom_range(0, 9))
            4, 5:
            begin
                xi = int'($urandom_range(0, 16383)) - 8192;
                bi = int'($urandom_range(0, 255)) - 128;
            end
            6:
            begin
                // hover around the clamp bounds
                xi = ($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 6)) - 3;
                bi = int'($urandom_range(0, 4)) - 2;
            end
            7, 8:
            begin
                xi = 32767 - int'($urandom_range(0, 4095));
                bi = int'($urandom_range(0, 8191));
                if ($urandom_range(0, 1)) begin
                    xi = -xi - 1;
                    bi = -bi - 1;
                end
            end
            9:
            begin
                xi = int'($urandom_range(0, 65535)) - 32768;
                bi = -xi + int'($urandom_range(0, 64)) - 32;
                if (bi > 32767)
                    bi = 32767;
            end
            default:
            begin
                xi = int'($urandom);
                bi = int'($urandom);
            end
        endcase
        send_beat(xi[DW-1:0], bi[DW-1:0], nad_op_t'($urandom_range(0, 3)));
    endtask

    initial
    begin
        rst_n                    <= 1'b0;
        sample_if.valid          <= 1'b0;
        sample_if.pre_activation <= '0;
        sample_if.bias           <= '0;
        sample_if.opcode         <= OP_LOGISTIC;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int op = 0; op < 4; op++) begin
            send_beat(16'sh4000, 16'sh4000, nad_op_t'(op));
            sender_gap();
            send_beat(-16'sd32768, -16'sd1, nad_op_t'(op));
            send_beat(16'sd0, 16'sd0, nad_op_t'(op));
            send_beat(-16'sd1, 16'sd0, nad_op_t'(op));
            sender_gap();
        end
        send_beat(16'sd4096, 16'sd0, OP_CLAMP);
        send_beat(-16'sd4096, 16'sd0, OP_CLAMP);
        send_beat(16'sd4097, 16'sd0, OP_CLAMP);
        send_beat(-16'sd4097, 16'sd0, OP_CLAMP);
        send_beat(16'sd32767, 16'sd0, OP_LOGISTIC);
        send_beat(-16'sd32768, 16'sd0, OP_LOGISTIC);
        send_beat(16'sd4096, 16'sd0, OP_BIPOLAR);
        sender_gap();

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            // hold a gap-free stretch mid-run and at the tail
            idle_on = !(i >= RANDOM_BEATS - QUIET_TAIL || (i >= 700 && i < 850));
            random_beat();
            sender_gap();
        end
        sample_if.valid <= 1'b0;

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.waiting() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
